// ===== sv/kwm_pkg.sv =====
// Shared constants and helpers for the k-way sorted list merge.
`default_nettype none
package kwm_pkg;
	localparam int MAX_LISTS = 8;
	localparam int MAX_LEN   = 8;
	localparam int DEPTH     = MAX_LISTS * MAX_LEN;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int KCNT_W    = $clog2(MAX_LISTS + 1);
	localparam int CFG_W     = 4;
	localparam int DATA_W    = 32;

	localparam logic REG_LIST_COUNT  = 1'b0;
	localparam logic REG_LIST_LENGTH = 1'b1;

	function automatic logic [KCNT_W-1:0] sat_count(input logic [CFG_W-1:0] raw);
		logic [KCNT_W-1:0] r;
		if (raw == '0) begin
			r = KCNT_W'(1);
		end else if (32'(raw) > MAX_LISTS) begin
			r = KCNT_W'(MAX_LISTS);
		end else begin
			r = KCNT_W'(raw);
		end
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] sat_length(input logic [CFG_W-1:0] raw);
		logic [LEN_W-1:0] r;
		if (raw == '0) begin
			r = LEN_W'(1);
		end else if (32'(raw) > MAX_LEN) begin
			r = LEN_W'(MAX_LEN);
		end else begin
			r = LEN_W'(raw);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/kwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/k_way_sorted_list_merge.sv =====
// Top level: list loader, iterative two-way merge sequencer and result emitter.
// Loading: one value per cycle, busy stays low until the last value of the run.
// Merge: list i (from 0) is merged into the running result of lists 0..i-1, one output
// word per ST_MRD/ST_MWR pair, via one shared compare/select unit on ping-pong merge buffers.
// Emit: one result per cycle, no stall; the strobe is registered through emit_s1 and valid_q.
// Reset: registers return to 1, load count to 0; RAM contents are not cleared.
`default_nettype none
module k_way_sorted_list_merge
	import kwm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          valid,
	output logic signed      [DATA_W-1:0] sorted_value,
	output logic                          last,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [2:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready
);
	typedef enum logic [1:0] {ST_LOAD, ST_MRD, ST_MWR, ST_EMIT} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    count_q;
	logic [CFG_W-1:0]    length_q;
	logic [CNT_W-1:0]    load_q;
	logic [CNT_W-1:0]    base_q;
	logic [CNT_W-1:0]    ia_q;
	logic [LEN_W-1:0]    ib_q;
	logic                par_q;
	logic                emit_s1;
	logic                last_s1;
	logic                valid_q;
	logic [DATA_W-1:0]   value_q;
	logic                last_q;

	logic [KCNT_W-1:0]   k_eff;
	logic [LEN_W-1:0]    n_eff;
	logic [CNT_W-1:0]    total;
	logic                accept;
	logic                cfg_wr;
	logic                cfg_idx;
	logic [CNT_W-1:0]    load_ptr;
	logic [CNT_W-1:0]    out_idx;
	logic [CNT_W-1:0]    st_raddr;
	logic [DATA_W-1:0]   st_rdata;
	logic [DATA_W-1:0]   b0_rdata;
	logic [DATA_W-1:0]   b1_rdata;
	logic [DATA_W-1:0]   src_rdata;
	logic                take_b;
	logic [DATA_W-1:0]   merge_word;
	logic                b0_we;
	logic                b1_we;

	assign k_eff   = sat_count(count_q);
	assign n_eff   = sat_length(length_q);
	assign total   = CNT_W'(CNT_W'(k_eff) * CNT_W'(n_eff));
	assign accept  = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2];
	assign pready  = 1'b1;
	assign busy    = (state_q != ST_LOAD);

	assign load_ptr  = (load_q >= total) ? '0 : load_q;
	assign out_idx   = CNT_W'(ia_q + CNT_W'(ib_q));
	assign st_raddr  = CNT_W'(base_q + CNT_W'(ib_q));
	assign src_rdata = par_q ? b1_rdata : b0_rdata;
	assign take_b    = (ia_q == base_q) ||
		((ib_q != n_eff) && ($signed(src_rdata) > $signed(st_rdata)));
	assign merge_word = take_b ? st_rdata : src_rdata;
	assign b0_we     = (state_q == ST_MWR) && par_q;
	assign b1_we     = (state_q == ST_MWR) && !par_q;

	always_comb begin
		case (cfg_idx)
			REG_LIST_COUNT:  prdata = 32'(count_q);
			REG_LIST_LENGTH: prdata = 32'(length_q);
			default:         prdata = '0;
		endcase
	end

	kwm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (load_ptr[ADDR_W-1:0]),
		.wdata (value),
		.raddr (st_raddr[ADDR_W-1:0]),
		.rdata (st_rdata)
	);

	kwm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_buf0 (
		.clk   (clk),
		.we    (b0_we),
		.waddr (out_idx[ADDR_W-1:0]),
		.wdata (merge_word),
		.raddr (ia_q[ADDR_W-1:0]),
		.rdata (b0_rdata)
	);

	kwm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_buf1 (
		.clk   (clk),
		.we    (b1_we),
		.waddr (out_idx[ADDR_W-1:0]),
		.wdata (merge_word),
		.raddr (ia_q[ADDR_W-1:0]),
		.rdata (b1_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= CFG_W'(1);
			length_q <= CFG_W'(1);
			load_q   <= '0;
			base_q   <= '0;
			ia_q     <= '0;
			ib_q     <= '0;
			par_q    <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			emit_s1 <= 1'b0;
			valid_q <= emit_s1;
			last_q  <= last_s1;
			if (cfg_wr) begin
				case (cfg_idx)
					REG_LIST_COUNT:  count_q  <= pwdata[CFG_W-1:0];
					REG_LIST_LENGTH: length_q <= pwdata[CFG_W-1:0];
					default:         ;
				endcase
				load_q <= '0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (CNT_W'(load_ptr + 1'b1) == total) begin
							load_q  <= '0;
							base_q  <= '0;
							ia_q    <= '0;
							ib_q    <= '0;
							state_q <= ST_MRD;
						end else begin
							load_q <= CNT_W'(load_ptr + 1'b1);
						end
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					if (take_b) begin
						ib_q <= LEN_W'(ib_q + 1'b1);
					end else begin
						ia_q <= CNT_W'(ia_q + 1'b1);
					end
					if (CNT_W'(out_idx + 1'b1) == CNT_W'(base_q + CNT_W'(n_eff))) begin
						par_q <= !par_q;
						ia_q  <= '0;
						ib_q  <= '0;
						base_q <= CNT_W'(base_q + CNT_W'(n_eff));
						if (CNT_W'(base_q + CNT_W'(n_eff)) == total) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MRD;
						end
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_EMIT: begin
					emit_s1 <= 1'b1;
					last_s1 <= (CNT_W'(ia_q + 1'b1) == total);
					ia_q    <= CNT_W'(ia_q + 1'b1);
					if (CNT_W'(ia_q + 1'b1) == total) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result word needs no reset
	always_ff @(posedge clk) begin
		value_q <= src_rdata;
	end

	assign valid        = valid_q;
	assign sorted_value = $signed(value_q);
	assign last         = last_q;

	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid) else $error("strobe after last result");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (CNT_W'(load_ptr + 1'b1) == total) |=> busy)
		else $error("final request did not start merge");

	a_merge_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MWR) |-> (ia_q <= base_q) && (ib_q <= n_eff))
		else $error("merge index out of range");

	a_emit_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid) |-> $past(busy, 2)) else $error("result without emit phase");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for k_way_sorted_list_merge: directed and random runs checked against a merge predictor.
module tb_top;
	import kwm_pkg::*;

	localparam int ITEM_TARGET  = 460;
	localparam int SETTLE_CYC   = 12;
	localparam int TAIL_CYC     = 40;
	localparam int INT_MIN      = 32'sh8000_0000;
	localparam int INT_MAX      = 32'sh7fff_ffff;

	typedef struct {
		int val;
		bit fin;
	} merge_out_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [DATA_W-1:0] value;
	logic                     valid;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [2:0]               paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	// predictor state
	logic [CFG_W-1:0] cfg_lists;
	logic [CFG_W-1:0] cfg_len;
	int               list_mem [DEPTH];
	int               load_pos;
	merge_out_t       expected_merge_q [$];

	int errors;
	int items_sent;
	int runs_done;
	int results_checked;
	int cfg_writes;
	int burst_left;

	k_way_sorted_list_merge u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.valid       (valid),
		.sorted_value(sorted_value),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int lists_in_use();
		if (cfg_lists == 0) return 1;
		if (int'(cfg_lists) > MAX_LISTS) return MAX_LISTS;
		return int'(cfg_lists);
	endfunction

	function automatic int len_in_use();
		if (cfg_len == 0) return 1;
		if (int'(cfg_len) > MAX_LEN) return MAX_LEN;
		return int'(cfg_len);
	endfunction

	// running result merged with each next list; ties keep the running element first
	function automatic void merge_lists();
		int         k;
		int         n;
		int         ia;
		int         ib;
		int         run_q [$];
		int         next_q [$];
		merge_out_t o;
		k = lists_in_use();
		n = len_in_use();
		for (int j = 0; j < n; j++) run_q.push_back(list_mem[j]);
		for (int l = 1; l < k; l++) begin
			next_q = {};
			ia = 0;
			ib = 0;
			while (ia < run_q.size() || ib < n) begin
				if (ia == run_q.size()) begin
					next_q.push_back(list_mem[l*n + ib]);
					ib++;
				end else if (ib == n) begin
					next_q.push_back(run_q[ia]);
					ia++;
				end else if (run_q[ia] > list_mem[l*n + ib]) begin
					next_q.push_back(list_mem[l*n + ib]);
					ib++;
				end else begin
					next_q.push_back(run_q[ia]);
					ia++;
				end
			end
			run_q = next_q;
		end
		foreach (run_q[i]) begin
			o.val = run_q[i];
			o.fin = (i == run_q.size() - 1);
			expected_merge_q.push_back(o);
		end
	endfunction

	function automatic void absorb_value(input int v);
		int total;
		total = lists_in_use() * len_in_use();
		if (load_pos >= total) load_pos = 0;
		list_mem[load_pos] = v;
		load_pos++;
		if (load_pos == total) begin
			merge_lists();
			load_pos = 0;
			runs_done++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		merge_out_t want;
		if (arst_n && valid) begin
			if (expected_merge_q.size() == 0) begin
				$error("unexpected result: sorted_value %0d last %0b", sorted_value, last);
				errors++;
			end else begin
				want = expected_merge_q.pop_front();
				results_checked++;
				if (sorted_value !== want.val) begin
					$error("sorted_value mismatch: expected %0d, got %0d", want.val, sorted_value);
					errors++;
				end
				if (last !== want.fin) begin
					$error("last mismatch: expected %0b, got %0b", want.fin, last);
					errors++;
				end
			end
		end
	end

	task automatic send_value(input int v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		absorb_value(v);
		items_sent++;
	endtask

	// bursts of requests with random gaps between them
	task automatic send_paced(input int v);
		int gap;
		send_value(v);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_merge_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [CFG_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(data);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_LIST_COUNT) cfg_lists = data;
		else cfg_len = data;
		load_pos = 0;
		cfg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic idx, input logic [CFG_W-1:0] want);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got[CFG_W-1:0] !== want) begin
			$error("prdata mismatch at register %0d: expected %0d, got %0d", idx, want,
				got[CFG_W-1:0]);
			errors++;
		end
	endtask

	task automatic set_config(input logic [CFG_W-1:0] k_raw, input logic [CFG_W-1:0] n_raw);
		wait_drained();
		apb_write(REG_LIST_COUNT, k_raw);
		apb_write(REG_LIST_LENGTH, n_raw);
	endtask

	task automatic test_reset_defaults();
		send_value(INT_MIN);
		send_value(INT_MAX);
		wait_drained();
	endtask

	task automatic test_register_access();
		apb_write(REG_LIST_COUNT, 4'd5);
		apb_write(REG_LIST_LENGTH, 4'd3);
		apb_check(REG_LIST_COUNT, 4'd5);
		apb_check(REG_LIST_LENGTH, 4'd3);
		apb_write(REG_LIST_COUNT, 4'd0);
		apb_write(REG_LIST_LENGTH, 4'd15);
		apb_check(REG_LIST_COUNT, 4'd0);
		apb_check(REG_LIST_LENGTH, 4'd15);
	endtask

	// zero and oversize settings clamp
	task automatic test_saturation();
		int one_list [8];
		one_list = '{INT_MIN, -1, 0, 1, 32'sh5555_5555, 32'shaaaa_aaaa, 100, INT_MAX};
		foreach (one_list[i]) send_value(one_list[i]);
		set_config(4'd15, 4'd0);
		for (int i = 0; i < 8; i++) send_value(INT_MAX - i * 32'sh1000_0000);
		wait_drained();
	endtask

	task automatic test_ties_extremes();
		set_config(4'd2, 4'd2);
		send_value(INT_MIN);
		send_value(INT_MAX);
		send_value(INT_MIN);
		send_value(INT_MAX);
		wait_drained();
	endtask

	// a register write mid-load drops the partial run
	task automatic test_dropped_load();
		set_config(4'd2, 4'd1);
		send_value(7);
		wait_drained();
		apb_write(REG_LIST_COUNT, 4'd2);
		send_value(-5);
		send_value(3);
		wait_drained();
	endtask

	task automatic send_list(input int n, input int shape);
		int q [$];
		int v;
		for (int i = 0; i < n; i++) begin
			case (shape)
				0: v = $urandom_range(0, 6) - 3;
				1: v = ($urandom_range(0, 1) == 0) ? INT_MIN + $urandom_range(0, 2)
					: INT_MAX - $urandom_range(0, 2);
				default: v = $urandom;
			endcase
			q.push_back(v);
		end
		if ($urandom_range(0, 6) != 0) q.sort();
		foreach (q[i]) send_paced(q[i]);
	endtask

	task automatic test_random_runs();
		int               r;
		int               k;
		int               n;
		int               part;
		logic [CFG_W-1:0] k_raw;
		logic [CFG_W-1:0] n_raw;
		burst_left = $urandom_range(1, 12);
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				k_raw = 4'd8;
				n_raw = 4'd8;
			end else if (r < 20) begin
				k_raw = $urandom_range(0, 15);
				n_raw = $urandom_range(0, 15);
			end else begin
				k_raw = $urandom_range(1, 4);
				n_raw = $urandom_range(1, 4);
			end
			if ($urandom_range(0, 3) != 0) set_config(k_raw, n_raw);
			k = lists_in_use();
			n = len_in_use();
			if ($urandom_range(0, 19) == 0 && k * n > 1) begin
				part = $urandom_range(1, k * n - 1);
				for (int i = 0; i < part; i++) send_paced($urandom);
				wait_drained();
				apb_write(REG_LIST_LENGTH, cfg_len);
			end
			for (int l = 0; l < k; l++) begin
				r = $urandom_range(0, 9);
				send_list(n, (r < 3) ? 0 : (r < 4) ? 1 : 2);
			end
		end
		wait_drained();
	endtask

	initial begin
		errors          = 0;
		items_sent      = 0;
		runs_done       = 0;
		results_checked = 0;
		cfg_writes      = 0;
		cfg_lists       = 4'd1;
		cfg_len         = 4'd1;
		load_pos        = 0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		value   <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_access();
		test_saturation();
		test_ties_extremes();
		test_dropped_load();
		test_random_runs();

		repeat (TAIL_CYC) @(posedge clk);
		if (expected_merge_q.size() != 0) begin
			$error("%0d merged values never arrived", expected_merge_q.size());
			errors++;
		end
		$display("Loaded %0d values over %0d merge runs, %0d register writes.",
			items_sent, runs_done, cfg_writes);
		$display("Checked %0d merged outputs, %0d errors.", results_checked, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/kwm_pkg.sv
sv/kwm_ram.sv
sv/k_way_sorted_list_merge.sv
dv/tb_top.sv
